// ----- src/okcs_pkg.sv -----
// ---------------------------------------------------------------------------
// okcs_pkg: shared constants, types and helpers for the OKLab chroma scaler
// Coefficient tables (Q.20), working widths and the rounding helpers used by
// the LMS, Lab and RGB sections.
// ---------------------------------------------------------------------------
package okcs_pkg;

  // Pixel format: signed, two integer bits, rest fraction
  localparam int PIXEL_BITS = 16;
  localparam int FRAC_IN    = PIXEL_BITS - 2;
  // Working fraction of all intermediates
  localparam int WFRAC      = 20;

  // Chroma gain register, unsigned Q4.12
  localparam int              GAIN_W     = 16;
  localparam int              GAIN_FRAC  = 12;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

  // Cube root: one restoring step per pipeline stage
  localparam int CB_STEPS = WFRAC + 1;
  localparam int MAG_W    = WFRAC + 2;
  localparam int X_W      = 3 * WFRAC + 2;
  localparam int Y_W      = WFRAC + 1;
  localparam int SQ_W     = 2 * Y_W;

  // Clamp limits in Q.20, pixel limits in the pixel format
  localparam logic signed [63:0] LMS_CLAMP = 64'sd1 <<< 24;
  localparam logic signed [63:0] RGB_CLAMP = 64'sd1 <<< 22;
  localparam logic signed [63:0] PX_MAX    = (64'sd1 <<< (PIXEL_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] PX_MIN    = -(64'sd1 <<< (PIXEL_BITS - 1));

  typedef logic signed [PIXEL_BITS-1:0] px_t;
  typedef logic [MAG_W-1:0]             mag_t;
  typedef logic [X_W-1:0]               cb_x_t;
  typedef logic [Y_W-1:0]               cb_y_t;
  typedef logic [SQ_W-1:0]              cb_sq_t;
  typedef logic [SQ_W+1:0]              cb_t_t;
  typedef logic [SQ_W+3:0]              cb_b_t;
  typedef logic signed [Y_W:0]          root_t;
  typedef logic signed [25:0]           lab_t;
  typedef logic signed [29:0]           chroma_t;
  typedef logic signed [25:0]           lin_t;
  typedef logic signed [29:0]           lin2_t;
  typedef logic signed [33:0]           cube_t;
  typedef logic signed [23:0]           rgbw_t;
  typedef logic signed [23:0]           coef_t;

  localparam coef_t TO_LMS [3][3] = '{
    '{ 24'sd432246,  24'sd562385,  24'sd53945  },
    '{ 24'sd222197,  24'sd713765,  24'sd112614 },
    '{ 24'sd92592,   24'sd295404,  24'sd660581 }
  };
  localparam coef_t TO_LAB [3][3] = '{
    '{ 24'sd220677,  24'sd832169,  -24'sd4270   },
    '{ 24'sd2074082, -24'sd2546563, 24'sd472482 },
    '{ 24'sd27162,   24'sd820796,  -24'sd847958 }
  };
  localparam coef_t FROM_LAB [3][3] = '{
    '{ 24'sd1048576, 24'sd415590,  24'sd226287   },
    '{ 24'sd1048576, -24'sd110689, -24'sd66956   },
    '{ 24'sd1048576, -24'sd93831,  -24'sd1354221 }
  };
  localparam coef_t TO_RGB [3][3] = '{
    '{ 24'sd4274773,  -24'sd3468387, 24'sd242190  },
    '{ -24'sd1330054, 24'sd2736529,  -24'sd357900 },
    '{ -24'sd4400,    -24'sd737588,  24'sd1790564 }
  };

  // Shift right by n with rounding half away from zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] v, input int n);
    logic signed [63:0] h;
    h = 64'sd1 <<< (n - 1);
    if (v[63]) h = h - 64'sd1;
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v,
                                               input logic signed [63:0] lo,
                                               input logic signed [63:0] hi);
    logic signed [63:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ----- src/okcs_lms.sv -----
// ---------------------------------------------------------------------------
// okcs_lms: RGB to LMS matrix
// Registers the nine products, then rounds each row sum to Q.20 and splits
// it into sign and magnitude for the cube root.
// ---------------------------------------------------------------------------
module okcs_lms (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  okcs_pkg::px_t       px [3],
  output logic                out_valid,
  output okcs_pkg::mag_t      mag [3],
  output logic [2:0]          neg
);

  logic [1:0]         vs;
  logic signed [39:0] prod [3][3];
  logic signed [63:0] lms [3];

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[0], in_valid};
    end
  end

  // Stage 1: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= px[j] * okcs_pkg::TO_LMS[i][j];
        end
      end
    end
  end

  // Row sums rounded to Q.20
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lms[i] = okcs_pkg::rnd(64'(prod[i][0]) + 64'(prod[i][1]) + 64'(prod[i][2]),
                             okcs_pkg::FRAC_IN);
    end
  end

  // Stage 2: sign and magnitude
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg[i] <= lms[i][63];
        mag[i] <= lms[i][63] ? okcs_pkg::mag_t'(-lms[i]) : okcs_pkg::mag_t'(lms[i]);
      end
    end
  end

  assign out_valid = vs[1];

endmodule

// ----- src/okcs_cbrt.sv -----
// ---------------------------------------------------------------------------
// okcs_cbrt: pipelined integer cube root, three lanes
// Each stage resolves one root bit of floor(cbrt(mag * 2^40)), keeping the
// partial root and its square so no multiplier is needed.
// ---------------------------------------------------------------------------
module okcs_cbrt (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  okcs_pkg::mag_t      mag [3],
  input  logic [2:0]          in_neg,
  output logic                out_valid,
  output okcs_pkg::cb_y_t     root [3],
  output logic [2:0]          out_neg
);

  logic                st_valid [okcs_pkg::CB_STEPS];
  logic [2:0]          st_neg   [okcs_pkg::CB_STEPS];
  okcs_pkg::cb_x_t     st_x     [okcs_pkg::CB_STEPS][3];
  okcs_pkg::cb_y_t     st_y     [okcs_pkg::CB_STEPS][3];
  okcs_pkg::cb_sq_t    st_sq    [okcs_pkg::CB_STEPS][3];

  for (genvar k = 0; k < okcs_pkg::CB_STEPS; k++) begin : g_step
    localparam int SH = 3 * (okcs_pkg::CB_STEPS - 1 - k);

    logic             cv;
    logic [2:0]       cneg;
    okcs_pkg::cb_x_t  cx  [3];
    okcs_pkg::cb_y_t  cy  [3];
    okcs_pkg::cb_sq_t csq [3];
    okcs_pkg::cb_x_t  nx  [3];
    okcs_pkg::cb_y_t  ny  [3];
    okcs_pkg::cb_sq_t nsq [3];

    // Select stage source
    if (k == 0) begin : g_head
      always_comb begin
        cv   = in_valid;
        cneg = in_neg;
        for (int i = 0; i < 3; i++) begin
          cx[i]  = okcs_pkg::cb_x_t'(mag[i]) << (2 * okcs_pkg::WFRAC);
          cy[i]  = '0;
          csq[i] = '0;
        end
      end
    end else begin : g_body
      always_comb begin
        cv   = st_valid[k-1];
        cneg = st_neg[k-1];
        for (int i = 0; i < 3; i++) begin
          cx[i]  = st_x[k-1][i];
          cy[i]  = st_y[k-1][i];
          csq[i] = st_sq[k-1][i];
        end
      end
    end

    // Try the next root bit: b = 3*y*(y+1)+1 against the remainder
    always_comb begin
      okcs_pkg::cb_y_t  y2;
      okcs_pkg::cb_sq_t sq4;
      okcs_pkg::cb_t_t  t;
      okcs_pkg::cb_b_t  b;
      okcs_pkg::cb_x_t  xs;
      okcs_pkg::cb_x_t  bs;
      for (int i = 0; i < 3; i++) begin
        y2  = {cy[i][okcs_pkg::Y_W-2:0], 1'b0};
        sq4 = {csq[i][okcs_pkg::SQ_W-3:0], 2'b00};
        t   = okcs_pkg::cb_t_t'(sq4) + okcs_pkg::cb_t_t'(y2);
        b   = okcs_pkg::cb_b_t'({t, 1'b0}) + okcs_pkg::cb_b_t'(t) + okcs_pkg::cb_b_t'(1);
        xs  = cx[i] >> SH;
        bs  = okcs_pkg::cb_x_t'(b) << SH;
        if (xs >= okcs_pkg::cb_x_t'(b)) begin
          nx[i]  = cx[i] - bs;
          ny[i]  = y2 + okcs_pkg::cb_y_t'(1);
          nsq[i] = sq4 + okcs_pkg::cb_sq_t'({y2, 1'b1});
        end else begin
          nx[i]  = cx[i];
          ny[i]  = y2;
          nsq[i] = sq4;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (en) begin
        st_valid[k] <= cv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st_neg[k] <= cneg;
        for (int i = 0; i < 3; i++) begin
          st_x[k][i]  <= nx[i];
          st_y[k][i]  <= ny[i];
          st_sq[k][i] <= nsq[i];
        end
      end
    end
  end

  always_comb begin
    out_valid = st_valid[okcs_pkg::CB_STEPS-1];
    out_neg   = st_neg[okcs_pkg::CB_STEPS-1];
    for (int i = 0; i < 3; i++) begin
      root[i] = st_y[okcs_pkg::CB_STEPS-1][i];
    end
  end

endmodule

// ----- src/okcs_lab.sv -----
// ---------------------------------------------------------------------------
// okcs_lab: LMS' to OKLab matrix and chroma gain
// Restores the root signs, applies the Lab matrix, then scales a and b by
// the Q4.12 gain.
// ---------------------------------------------------------------------------
module okcs_lab (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  okcs_pkg::cb_y_t          root [3],
  input  logic [2:0]               neg,
  input  logic [okcs_pkg::GAIN_W-1:0] gain,
  output logic                     out_valid,
  output okcs_pkg::lab_t           lab_l,
  output okcs_pkg::chroma_t        lab_a,
  output okcs_pkg::chroma_t        lab_b
);

  logic [3:0]          vs;
  okcs_pkg::root_t     cr [3];
  logic signed [45:0]  prod [3][3];
  okcs_pkg::lab_t      lab [3];
  okcs_pkg::lab_t      l3;
  logic signed [42:0]  ga;
  logic signed [42:0]  gb;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[2:0], in_valid};
    end
  end

  // Signed roots
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cr[i] = neg[i] ? -okcs_pkg::root_t'(root[i]) : okcs_pkg::root_t'(root[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: products
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod[i][j] <= cr[j] * okcs_pkg::TO_LAB[i][j];
        end
      end
      // Stage 2: row sums to Q.20
      for (int i = 0; i < 3; i++) begin
        lab[i] <= okcs_pkg::lab_t'(okcs_pkg::rnd(
                    64'(prod[i][0]) + 64'(prod[i][1]) + 64'(prod[i][2]),
                    okcs_pkg::WFRAC));
      end
      // Stage 3: gain products
      l3 <= lab[0];
      ga <= lab[1] * $signed({1'b0, gain});
      gb <= lab[2] * $signed({1'b0, gain});
      // Stage 4: round gain products
      lab_l <= l3;
      lab_a <= okcs_pkg::chroma_t'(okcs_pkg::rnd(64'(ga), okcs_pkg::GAIN_FRAC));
      lab_b <= okcs_pkg::chroma_t'(okcs_pkg::rnd(64'(gb), okcs_pkg::GAIN_FRAC));
    end
  end

  assign out_valid = vs[3];

endmodule

// ----- src/okcs_rgb.sv -----
// ---------------------------------------------------------------------------
// okcs_rgb: OKLab back to linear RGB
// Inverse Lab matrix with clamp, cube per channel in two multiply stages,
// final matrix, clamp and conversion to the pixel format.
// ---------------------------------------------------------------------------
module okcs_rgb (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  okcs_pkg::lab_t    lab_l,
  input  okcs_pkg::chroma_t lab_a,
  input  okcs_pkg::chroma_t lab_b,
  output logic              out_valid,
  output okcs_pkg::px_t     px [3]
);

  logic [8:0]          vs;
  logic signed [53:0]  pl [3];
  logic signed [53:0]  pa [3];
  logic signed [53:0]  pb [3];
  okcs_pkg::lin_t      v2s [3];
  logic signed [50:0]  sq  [3];
  okcs_pkg::lin_t      v3s [3];
  okcs_pkg::lin2_t     vsq [3];
  okcs_pkg::lin_t      v4s [3];
  logic signed [55:0]  cu  [3];
  okcs_pkg::cube_t     t6  [3];
  logic signed [57:0]  p7  [3][3];
  okcs_pkg::rgbw_t     rgb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= '0;
    end else if (en) begin
      vs <= {vs[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        // Stage 1: inverse matrix products
        pl[i] <= lab_l * okcs_pkg::FROM_LAB[i][0];
        pa[i] <= lab_a * okcs_pkg::FROM_LAB[i][1];
        pb[i] <= lab_b * okcs_pkg::FROM_LAB[i][2];
        // Stage 2: sum, round, clamp to +-16.0
        v2s[i] <= okcs_pkg::lin_t'(okcs_pkg::clamp(
                    okcs_pkg::rnd(64'(pl[i]) + 64'(pa[i]) + 64'(pb[i]), okcs_pkg::WFRAC),
                    -okcs_pkg::LMS_CLAMP, okcs_pkg::LMS_CLAMP));
        // Stage 3: square
        sq[i]  <= v2s[i] * v2s[i];
        v3s[i] <= v2s[i];
        // Stage 4: round square
        vsq[i] <= okcs_pkg::lin2_t'(okcs_pkg::rnd(64'(sq[i]), okcs_pkg::WFRAC));
        v4s[i] <= v3s[i];
        // Stage 5: cube
        cu[i]  <= vsq[i] * v4s[i];
        // Stage 6: round cube
        t6[i]  <= okcs_pkg::cube_t'(okcs_pkg::rnd(64'(cu[i]), okcs_pkg::WFRAC));
        // Stage 7: RGB matrix products
        for (int j = 0; j < 3; j++) begin
          p7[i][j] <= t6[j] * okcs_pkg::TO_RGB[i][j];
        end
        // Stage 8: sum, round, clamp to +-4.0
        rgb[i] <= okcs_pkg::rgbw_t'(okcs_pkg::clamp(
                    okcs_pkg::rnd(64'(p7[i][0]) + 64'(p7[i][1]) + 64'(p7[i][2]),
                                  okcs_pkg::WFRAC),
                    -okcs_pkg::RGB_CLAMP, okcs_pkg::RGB_CLAMP));
        // Stage 9: to pixel format, saturate
        px[i]  <= okcs_pkg::px_t'(okcs_pkg::clamp(
                    okcs_pkg::rnd(64'(rgb[i]), okcs_pkg::WFRAC - okcs_pkg::FRAC_IN),
                    okcs_pkg::PX_MIN, okcs_pkg::PX_MAX));
      end
    end
  end

  assign out_valid = vs[8];

endmodule

// ----- src/oklab_chroma_scaler.sv -----
// ---------------------------------------------------------------------------
// oklab_chroma_scaler: chroma gain in OKLab on a linear RGB pixel stream
// RGB -> LMS -> cube root -> Lab, a and b scaled by chroma_gain, then back
// through the inverse matrix, cube and RGB matrix, saturated.
// ---------------------------------------------------------------------------
//
//  channel  | dir | handshake          | content
//  ---------+-----+--------------------+----------------------------------
//  s_*      | in  | s_tvalid/s_tready  | one pixel per request
//  m_*      | out | m_tvalid/m_tready  | one adjusted pixel per request
//  cfg_*    | in  | cfg_valid/cfg_ready| chroma_gain, Q4.12
//
// One pixel enters per cycle while the skid register is empty; a result
// passes the 36 pipeline stages (21 of them the cube root steps) and the
// output register. Reset (rst, synchronous) clears valid bits and loads a
// gain of 1.0. A skid register behind the output holds one result, so the
// pipeline keeps accepting while a result waits; it freezes only once the
// skid register fills.
// ---------------------------------------------------------------------------
module oklab_chroma_scaler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_red, in_green, in_blue
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // out_red, out_green, out_blue
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data   // chroma_gain
);

  logic [okcs_pkg::GAIN_W-1:0] gain;
  logic                        en;
  okcs_pkg::px_t               px_in [3];

  logic                        lms_valid;
  okcs_pkg::mag_t              lms_mag [3];
  logic [2:0]                  lms_neg;
  logic                        cb_valid;
  okcs_pkg::cb_y_t             cb_root [3];
  logic [2:0]                  cb_neg;
  logic                        lab_valid;
  okcs_pkg::lab_t              lab_l;
  okcs_pkg::chroma_t           lab_a;
  okcs_pkg::chroma_t           lab_b;
  logic                        rgb_valid;
  okcs_pkg::px_t               rgb_px [3];

  logic                        out_v;
  logic [47:0]                 out_d;
  logic                        skid_v;
  logic [47:0]                 skid_d;
  logic                        take;
  logic                        free;
  logic [47:0]                 pipe_d;

  // Gain register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= okcs_pkg::GAIN_RESET;
    end else if (cfg_valid) begin
      gain <= cfg_data;
    end
  end

  // Pipeline advances unless the skid register is occupied
  assign en       = ~skid_v;
  assign s_tready = en;

  assign px_in[0] = s_tdata[15:0];
  assign px_in[1] = s_tdata[31:16];
  assign px_in[2] = s_tdata[47:32];

  okcs_lms u_lms (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .px(px_in), .out_valid(lms_valid), .mag(lms_mag), .neg(lms_neg)
  );

  okcs_cbrt u_cbrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(lms_valid),
    .mag(lms_mag), .in_neg(lms_neg),
    .out_valid(cb_valid), .root(cb_root), .out_neg(cb_neg)
  );

  okcs_lab u_lab (
    .clk(clk), .rst(rst), .en(en), .in_valid(cb_valid),
    .root(cb_root), .neg(cb_neg), .gain(gain),
    .out_valid(lab_valid), .lab_l(lab_l), .lab_a(lab_a), .lab_b(lab_b)
  );

  okcs_rgb u_rgb (
    .clk(clk), .rst(rst), .en(en), .in_valid(lab_valid),
    .lab_l(lab_l), .lab_a(lab_a), .lab_b(lab_b),
    .out_valid(rgb_valid), .px(rgb_px)
  );

  assign pipe_d = {rgb_px[2], rgb_px[1], rgb_px[0]};
  assign take   = en & rgb_valid;
  assign free   = ~out_v | m_tready;

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (free) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v  <= take;
      end
    end else if (take) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (free) begin
      if (skid_v) begin
        out_d <= skid_d;
      end else if (take) begin
        out_d <= pipe_d;
      end
    end else if (take) begin
      skid_d <= pipe_d;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = out_d;

endmodule
